### rtl/core/jse_pkg.sv
`timescale 1ns / 1ps
// jse_pkg: shared types, character constants and helper functions for the
// JSON string escaper. No dependencies.
package jse_pkg;

  localparam logic [7:0] ChBsl   = 8'h5C;
  localparam logic [7:0] ChQuote = 8'h22;
  localparam logic [7:0] ChB     = 8'h62;
  localparam logic [7:0] ChF     = 8'h66;
  localparam logic [7:0] ChN     = 8'h6E;
  localparam logic [7:0] ChR     = 8'h72;
  localparam logic [7:0] ChT     = 8'h74;
  localparam logic [7:0] ChU     = 8'h75;
  localparam logic [7:0] ChV     = 8'h76;
  localparam logic [7:0] ChZero  = 8'h30;
  localparam logic [7:0] CtlBs   = 8'h08;
  localparam logic [7:0] CtlHt   = 8'h09;
  localparam logic [7:0] CtlLf   = 8'h0A;
  localparam logic [7:0] CtlVt   = 8'h0B;
  localparam logic [7:0] CtlFf   = 8'h0C;
  localparam logic [7:0] CtlCr   = 8'h0D;
  localparam logic [7:0] CtlLimit = 8'h20;

  // longest expansion: leading backslash plus \u00XX
  localparam int unsigned MaxOut = 7;
  localparam int unsigned IdxW   = $clog2(MaxOut + 1);

  localparam int unsigned FifoDepth = 2;
  localparam int unsigned FifoPtrW  = (FifoDepth > 1) ? $clog2(FifoDepth) : 1;
  localparam int unsigned FifoCntW  = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    KIND_PLAIN = 2'd0,  // the data byte itself
    KIND_ESC   = 2'd1,  // backslash, then the letter in data
    KIND_UNI   = 2'd2   // \u00XX of the data byte
  } kind_e;

  typedef struct packed {
    kind_e      kind;
    logic       pre;   // emit one extra backslash first
    logic [7:0] data;
    logic       last;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } fifo_stat_t;

  function automatic logic is_esc_letter(logic [7:0] c);
    return (c == ChQuote) || (c == ChBsl) || (c == ChB) || (c == ChF) ||
           (c == ChN) || (c == ChR) || (c == ChT);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    return (n < 4'd10) ? (ChZero + {4'b0, n}) : (8'h37 + {4'b0, n});
  endfunction

endpackage

### rtl/core/json_string_escaper_top.sv
`timescale 1ns / 1ps
// json_string_escaper_top: classifier, command queue and serializer.
// Depends on jse_pkg, jse_front, jse_cmd_fifo, jse_back.
//
//   channel | direction | handshake                 | payload
//   in      | input     | in_valid_i / in_ready_o   | in_byte_i, in_last_i
//   out     | output    | out_valid_o / out_ready_i | out_byte_o, out_last_o
//
// One output byte per cycle while out_ready_i is high; an input byte expands
// to 1 to 7 output bytes, one step each, so unstalled plain text runs at one
// byte per cycle. A two-entry command queue sits between classifier and
// serializer. Reset clears the pending-backslash flag, queue and output stage.
// The output is registered; in_ready_o drops only when the queue is full.
module json_string_escaper_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  output logic       out_valid_o,
  input  logic       out_ready_i,
  output logic [7:0] out_byte_o,
  output logic       out_last_o
);
  import jse_pkg::*;

  cmd_t       push_cmd;
  cmd_t       head_cmd;
  fifo_stat_t stat;
  logic       push;
  logic       pop;

  jse_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .stat_i     (stat),
    .push_o     (push),
    .cmd_o      (push_cmd)
  );

  jse_cmd_fifo u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .cmd_i  (push_cmd),
    .pop_i  (pop),
    .cmd_o  (head_cmd),
    .stat_o (stat)
  );

  jse_back u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (head_cmd),
    .stat_i      (stat),
    .pop_o       (pop),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_o  (out_byte_o),
    .out_last_o  (out_last_o)
  );

`ifndef SYNTHESIS
  a_stat_sane: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(stat.full && stat.empty))
    else $error("queue full and empty together");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !stat.full)
    else $error("push into full queue");

  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |-> !stat.empty)
    else $error("pop from empty queue");

  a_push_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |=> !stat.empty)
    else $error("transfer did not reach the queue");
`endif

endmodule

### rtl/core/jse_front.sv
`timescale 1ns / 1ps
// jse_front: accepts input bytes, tracks the pending-backslash flag and
// classifies each byte into an expansion command. Depends on jse_pkg.
module jse_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  logic [7:0]        in_byte_i,
  input  logic              in_last_i,
  input  jse_pkg::fifo_stat_t stat_i,
  output logic              push_o,
  output jse_pkg::cmd_t     cmd_o
);
  import jse_pkg::*;

  logic pend_q, pend_d;
  logic esc;
  logic pend_nx;

  assign in_ready_o = !stat_i.full;
  assign push_o     = in_valid_i && in_ready_o;

  always_comb begin
    esc         = is_esc_letter(in_byte_i);
    cmd_o.kind  = KIND_PLAIN;
    cmd_o.pre   = 1'b0;
    cmd_o.data  = in_byte_i;
    cmd_o.last  = in_last_i;
    pend_nx     = 1'b0;
    if (in_byte_i >= CtlLimit && !esc) begin
      cmd_o.pre = pend_q;
    end else if (!pend_q && in_byte_i == ChBsl) begin
      cmd_o.pre = in_last_i;
      pend_nx   = !in_last_i;
    end else begin
      cmd_o.pre = pend_q && !esc;
      case (in_byte_i)
        CtlBs: begin
          cmd_o.kind = KIND_ESC;
          cmd_o.data = ChB;
        end
        CtlHt: begin
          cmd_o.kind = KIND_ESC;
          cmd_o.data = ChT;
        end
        CtlLf: begin
          cmd_o.kind = KIND_ESC;
          cmd_o.data = ChN;
        end
        CtlVt: begin
          cmd_o.kind = KIND_ESC;
          cmd_o.data = ChV;
        end
        CtlFf: begin
          cmd_o.kind = KIND_ESC;
          cmd_o.data = ChF;
        end
        CtlCr: begin
          cmd_o.kind = KIND_ESC;
          cmd_o.data = ChR;
        end
        ChB, ChF, ChN, ChR, ChT, ChBsl: begin
          cmd_o.kind = KIND_PLAIN;
        end
        ChQuote: begin
          cmd_o.kind = KIND_PLAIN;
          cmd_o.pre  = !pend_q;
        end
        default: begin
          cmd_o.kind = KIND_UNI;
        end
      endcase
    end
  end

  assign pend_d = push_o ? pend_nx : pend_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= 1'b0;
    end else begin
      pend_q <= pend_d;
    end
  end

endmodule

### rtl/core/jse_cmd_fifo.sv
`timescale 1ns / 1ps
// jse_cmd_fifo: short command queue between classifier and serializer.
// Depends on jse_pkg.
module jse_cmd_fifo (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                push_i,
  input  jse_pkg::cmd_t       cmd_i,
  input  logic                pop_i,
  output jse_pkg::cmd_t       cmd_o,
  output jse_pkg::fifo_stat_t stat_o
);
  import jse_pkg::*;

  cmd_t                mem_q [FifoDepth];
  logic [FifoPtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0] cnt_q, cnt_d;

  assign stat_o.full  = (cnt_q == FifoCntW'(FifoDepth));
  assign stat_o.empty = (cnt_q == '0);
  assign cmd_o        = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push_i) begin
      wr_ptr_d = (wr_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop_i) begin
      rd_ptr_d = (rd_ptr_q == FifoPtrW'(FifoDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= cmd_i;
    end
  end

endmodule

### rtl/core/jse_back.sv
`timescale 1ns / 1ps
// jse_back: expands queued commands into output bytes, one per cycle while
// out_ready_i allows, behind a registered output stage. Depends on jse_pkg.
module jse_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  jse_pkg::cmd_t       cmd_i,
  input  jse_pkg::fifo_stat_t stat_i,
  output logic                pop_o,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic [7:0]          out_byte_o,
  output logic                out_last_o
);
  import jse_pkg::*;

  logic [IdxW-1:0] idx_q, idx_d;
  logic [IdxW-1:0] len;
  logic [IdxW-1:0] pos;
  logic            fin;
  logic            load;
  logic [7:0]      gen_byte;
  logic            valid_q, valid_d;
  logic [7:0]      byte_q, byte_d;
  logic            last_q, last_d;

  always_comb begin
    case (cmd_i.kind)
      KIND_PLAIN: len = IdxW'(1);
      KIND_ESC:   len = IdxW'(2);
      default:    len = IdxW'(6);
    endcase
    len = len + IdxW'(cmd_i.pre);
    fin = (idx_q == len - 1'b1);
    pos = idx_q - IdxW'(cmd_i.pre);
  end

  always_comb begin
    gen_byte = ChBsl;
    if (!(cmd_i.pre && idx_q == '0)) begin
      case (cmd_i.kind)
        KIND_PLAIN: gen_byte = cmd_i.data;
        KIND_ESC:   gen_byte = (pos == '0) ? ChBsl : cmd_i.data;
        default: begin
          case (pos)
            IdxW'(0): gen_byte = ChBsl;
            IdxW'(1): gen_byte = ChU;
            IdxW'(2), IdxW'(3): gen_byte = ChZero;
            IdxW'(4): gen_byte = hex_char(cmd_i.data[7:4]);
            default:  gen_byte = hex_char(cmd_i.data[3:0]);
          endcase
        end
      endcase
    end
  end

  always_comb begin
    load    = !valid_q || out_ready_i;
    pop_o   = load && !stat_i.empty && fin;
    valid_d = valid_q;
    byte_d  = byte_q;
    last_d  = last_q;
    idx_d   = idx_q;
    if (load) begin
      valid_d = !stat_i.empty;
      if (!stat_i.empty) begin
        byte_d = gen_byte;
        last_d = cmd_i.last && fin;
        idx_d  = fin ? '0 : idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else begin
      valid_q <= valid_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    byte_q <= byte_d;
    last_q <= last_d;
  end

  assign out_valid_o = valid_q;
  assign out_byte_o  = byte_q;
  assign out_last_o  = last_q;

endmodule

### sim/json_escape_checker.sv
`timescale 1ns / 1ps
// json_escape_checker: watches both channels of the JSON string escaper, predicts the
// escaped byte stream and compares every output transfer against it.
// Depends on jse_pkg.
module json_escape_checker
  import jse_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  input  logic       in_ready_i,
  input  logic [7:0] in_byte_i,
  input  logic       in_last_i,
  input  logic       out_valid_i,
  input  logic       out_ready_i,
  input  logic [7:0] out_byte_i,
  input  logic       out_last_i,
  output int         fail_count_o,
  output int         backlog_o
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } esc_byte_t;

  esc_byte_t escaped_q[$];
  esc_byte_t head;
  logic      bsl_open = 1'b0;

  function automatic logic kept_after_bsl(logic [7:0] c);
    case (c)
      ChQuote, ChBsl, ChB, ChF, ChN, ChR, ChT: return 1'b1;
      default: return 1'b0;
    endcase
  endfunction

  function automatic logic [7:0] nibble_ascii(logic [3:0] n);
    if (n > 4'd9) return 8'h37 + {4'b0, n};
    return ChZero + {4'b0, n};
  endfunction

  task automatic predict_escape(input logic [7:0] c, input logic last);
    logic [7:0] seq[$];
    logic       open_next;
    open_next = 1'b0;
    if (c >= CtlLimit && !kept_after_bsl(c)) begin
      if (bsl_open) seq.push_back(ChBsl);
      seq.push_back(c);
    end else if (!bsl_open && c == ChBsl) begin
      seq.push_back(ChBsl);
      if (last) seq.push_back(ChBsl);
      open_next = 1'b1;
    end else begin
      if (bsl_open && !kept_after_bsl(c)) seq.push_back(ChBsl);
      case (c)
        CtlBs: begin
          seq.push_back(ChBsl);
          seq.push_back(ChB);
        end
        CtlHt: begin
          seq.push_back(ChBsl);
          seq.push_back(ChT);
        end
        CtlLf: begin
          seq.push_back(ChBsl);
          seq.push_back(ChN);
        end
        CtlVt: begin
          seq.push_back(ChBsl);
          seq.push_back(ChV);
        end
        CtlFf: begin
          seq.push_back(ChBsl);
          seq.push_back(ChF);
        end
        CtlCr: begin
          seq.push_back(ChBsl);
          seq.push_back(ChR);
        end
        ChB, ChF, ChN, ChR, ChT: seq.push_back(c);
        ChQuote: begin
          if (!bsl_open) seq.push_back(ChBsl);
          seq.push_back(ChQuote);
        end
        ChBsl: seq.push_back(ChBsl);
        default: begin
          seq.push_back(ChBsl);
          seq.push_back(ChU);
          seq.push_back(ChZero);
          seq.push_back(ChZero);
          seq.push_back(nibble_ascii(c[7:4]));
          seq.push_back(nibble_ascii(c[3:0]));
        end
      endcase
    end
    foreach (seq[i]) begin
      escaped_q.push_back(esc_byte_t'{data: seq[i], last: last && (i == seq.size() - 1)});
    end
    bsl_open = open_next && !last;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      escaped_q.delete();
      bsl_open = 1'b0;
      fail_count_o = 0;
    end else begin
      if (in_valid_i && in_ready_i) predict_escape(in_byte_i, in_last_i);
      if (out_valid_i && out_ready_i) begin
        if (escaped_q.size() == 0) begin
          $display("%0t: unexpected transfer, expected none, actual byte %h last %b",
                   $time, out_byte_i, out_last_i);
          fail_count_o++;
        end else begin
          head = escaped_q.pop_front();
          if (head.data !== out_byte_i) begin
            $display("%0t: out_byte mismatch, expected %h, actual %h",
                     $time, head.data, out_byte_i);
            fail_count_o++;
          end
          if (head.last !== out_last_i) begin
            $display("%0t: out_last mismatch, expected %b, actual %b",
                     $time, head.last, out_last_i);
            fail_count_o++;
          end
        end
      end
    end
    backlog_o = escaped_q.size();
  end

endmodule

### sim/tb_json_string_escaper_top.sv
`timescale 1ns / 1ps
// tb_json_string_escaper_top: drives strings into the JSON string escaper with bursty
// input and stalling output, and reports the verdict. Depends on jse_pkg,
// json_string_escaper_top and json_escape_checker.
module tb_json_string_escaper_top;
  import jse_pkg::*;

  typedef enum logic [1:0] {
    RX_OPEN,
    RX_RANDOM,
    RX_PATTERN
  } rx_mode_e;

  localparam int unsigned StallLimit = 2000;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned ItemTarget = 430;
  localparam int unsigned DrainCycles = 20;

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_ready_o;
  logic [7:0] in_byte_i = 8'h00;
  logic       in_last_i = 1'b0;
  logic       out_valid_o;
  logic       out_ready_i = 1'b0;
  logic [7:0] out_byte_o;
  logic       out_last_o;

  int          fail_count;
  int          backlog;
  int          items_sent = 0;
  int          burst_left = 0;
  int          hold_asked = 0;
  int          hold_done = 0;
  int unsigned rx_tick = 0;
  int unsigned quiet_cycles = 0;
  rx_mode_e    rx_mode = RX_OPEN;

  json_string_escaper_top u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_byte_i  (in_byte_i),
    .in_last_i  (in_last_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_byte_o (out_byte_o),
    .out_last_o (out_last_o)
  );

  json_escape_checker u_checker (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_i  (in_ready_o),
    .in_byte_i   (in_byte_i),
    .in_last_i   (in_last_i),
    .out_valid_i (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_byte_i  (out_byte_o),
    .out_last_i  (out_last_o),
    .fail_count_o(fail_count),
    .backlog_o   (backlog)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // receiver: long hold on request, otherwise its own stall pattern
  always @(posedge clk_i) begin
    rx_tick++;
    if (hold_done != hold_asked) begin
      out_ready_i <= 1'b0;
      repeat (HoldCycles) @(posedge clk_i);
      hold_done = hold_asked;
    end else begin
      case (rx_mode)
        RX_OPEN:    out_ready_i <= 1'b1;
        RX_RANDOM:  out_ready_i <= ($urandom_range(0, 2) != 0);
        RX_PATTERN: out_ready_i <= ((rx_tick % 9) < 5);
        default:    out_ready_i <= 1'b1;
      endcase
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end
    end
  end

  task automatic send_char(input logic [7:0] c, input logic last);
    if (burst_left == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk_i);
      burst_left = $urandom_range(1, 24);
    end
    in_valid_i <= 1'b1;
    in_byte_i  <= c;
    in_last_i  <= last;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    burst_left--;
    items_sent++;
  endtask

  task automatic drain_output();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (backlog != 0) @(posedge clk_i);
  endtask

  function automatic logic [7:0] pick_char();
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 35) return 8'($urandom_range(8'h20, 8'h7E));
    if (roll < 50) return ChBsl;
    if (roll < 65) begin
      case ($urandom_range(0, 6))
        0: return ChQuote;
        1: return ChBsl;
        2: return ChB;
        3: return ChF;
        4: return ChN;
        5: return ChR;
        default: return ChT;
      endcase
    end
    if (roll < 80) return 8'($urandom_range(0, 8'h1F));
    if (roll < 90) return 8'($urandom_range(8'h80, 8'hFF));
    return 8'($urandom_range(0, 8'hFF));
  endfunction

  task automatic send_random_until(input int target, input int hold_at);
    int len;
    while (items_sent < target) begin
      if (hold_at >= 0 && items_sent >= hold_at && hold_asked == hold_done) begin
        hold_asked++;
        hold_at = -1;
      end
      if ($urandom_range(0, 9) == 0) begin
        // stray bytes with an arbitrary end mark
        send_char(8'($urandom_range(0, 8'hFF)), 1'($urandom_range(0, 1)));
      end else begin
        len = $urandom_range(1, 12);
        for (int i = 0; i < len; i++) send_char(pick_char(), i == len - 1);
      end
    end
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed strings
    rx_mode = RX_OPEN;
    send_char(8'h00, 1'b0);
    send_char(8'hFF, 1'b0);
    send_char(8'h1F, 1'b0);
    send_char(CtlBs, 1'b0);
    send_char(CtlHt, 1'b0);
    send_char(CtlLf, 1'b0);
    send_char(CtlVt, 1'b0);
    send_char(CtlFf, 1'b0);
    send_char(CtlCr, 1'b1);
    send_char(ChBsl, 1'b1);
    send_char(ChQuote, 1'b0);
    send_char(ChBsl, 1'b0);
    send_char(ChQuote, 1'b0);
    send_char(ChBsl, 1'b0);
    send_char(ChBsl, 1'b0);
    send_char(ChBsl, 1'b0);
    send_char(ChN, 1'b0);
    send_char(ChBsl, 1'b0);
    send_char(CtlLf, 1'b0);
    send_char(ChBsl, 1'b0);
    send_char(8'h78, 1'b0);
    send_char(ChB, 1'b0);
    send_char(ChT, 1'b0);
    send_char(8'h20, 1'b0);
    send_char(8'h7F, 1'b1);
    drain_output();

    rx_mode = RX_RANDOM;
    send_random_until(180, 100);
    drain_output();

    rx_mode = RX_PATTERN;
    send_random_until(320, -1);
    drain_output();

    rx_mode = RX_OPEN;
    send_random_until(ItemTarget, -1);
    drain_output();
    repeat (DrainCycles) @(posedge clk_i);

    if (fail_count == 0 && backlog == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule
